@@ rtl/core/prc_pkg.sv @@
// Package for the polygon rectangle clipper: register indexes, cell control
// type, cell state type and the per-cell control table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package prc_pkg;

    localparam int NUM_CELLS = 4;

    localparam logic [1:0] CFG_LEFT   = 2'd0;
    localparam logic [1:0] CFG_RIGHT  = 2'd1;
    localparam logic [1:0] CFG_BOTTOM = 2'd2;
    localparam logic [1:0] CFG_TOP    = 2'd3;

    // axis_y: the cell tests y rather than x; keep_below: inside means below the bound
    typedef struct packed {
        logic axis_y;
        logic keep_below;
    } t_clip_ctl;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_PREP = 6'b000010,
        S_MUL  = 6'b000100,
        S_DIV  = 6'b001000,
        S_FIN  = 6'b010000,
        S_EMIT = 6'b100000
    } t_cell_state;

    // cell order: max-x, max-y, min-x, min-y
    function automatic t_clip_ctl stage_ctl(input int s);
        t_clip_ctl c;
        c.axis_y     = (s == 1) || (s == 3);
        c.keep_below = (s == 0) || (s == 1);
        return c;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/prc_if.sv @@
// Channel interfaces of the polygon rectangle clipper: vertex requests,
// result requests and configuration writes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface prc_vtx_if #(parameter int COORD_BITS = 32);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] vertex_x;
    logic signed [COORD_BITS-1:0] vertex_y;
    logic                         final_vertex;
    modport source (output valid, vertex_x, vertex_y, final_vertex, input ready);
    modport sink   (input valid, vertex_x, vertex_y, final_vertex, output ready);
endinterface

interface prc_res_if #(parameter int COORD_BITS = 32);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_y;
    logic                         out_final;
    logic                         empty_result;
    modport source (output valid, out_x, out_y, out_final, empty_result, input ready);
    modport sink   (input valid, out_x, out_y, out_final, empty_result, output ready);
endinterface

interface prc_cfg_if #(parameter int COORD_BITS = 32);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   index;
    logic signed [COORD_BITS-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/prc_cell.sv @@
// One clip cell: a single Sutherland-Hodgman boundary with a serial
// multiplier and divider for the crossing point. Depends on prc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module prc_cell import prc_pkg::*; #(
    parameter int COORD_BITS = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire t_clip_ctl                    i_ctl,
    input  wire logic signed [COORD_BITS-1:0] i_bound,
    input  wire logic                         i_up_valid,
    output logic                              o_up_ready,
    input  wire logic signed [COORD_BITS-1:0] i_up_x,
    input  wire logic signed [COORD_BITS-1:0] i_up_y,
    input  wire logic                         i_up_end,
    output logic                              o_dn_valid,
    input  wire logic                         i_dn_ready,
    output logic signed [COORD_BITS-1:0]      o_dn_x,
    output logic signed [COORD_BITS-1:0]      o_dn_y,
    output logic                              o_dn_end
);
    localparam int CB = COORD_BITS;
    localparam int W  = COORD_BITS + 1;
    localparam int CW = $clog2(W + 1);

    t_cell_state      r_state;
    logic             r_has_first;
    logic [CB-1:0]    r_fu, r_fv, r_pu, r_pv, r_au, r_av, r_bu, r_bv, r_cv;
    logic             r_do_cross, r_do_b, r_do_end, r_neg;
    logic [W-1:0]     r_ma, r_md, r_ph, r_pl;
    logic [CW-1:0]    r_cnt;
    logic             r_ovld, r_oend;
    logic [CB-1:0]    r_ou, r_ov;

    logic [CB-1:0]    in_u, in_v, e_bu, e_bv;
    logic             ia, ib, out_free, acc, emit_go;
    logic signed [W-1:0] da, dn, dd;
    logic [W:0]       msum, dtry;
    logic             dge;
    logic [W-1:0]     sq, fsum;

    function automatic logic inside_b(input logic [CB-1:0] u, input logic signed [CB-1:0] b,
                                      input logic below);
        return below ? ($signed(u) < b) : ($signed(u) > b);
    endfunction

    function automatic logic [W-1:0] absw(input logic signed [W-1:0] v);
        return v[W-1] ? W'(-v) : W'(v);
    endfunction

    assign in_u = i_ctl.axis_y ? i_up_y : i_up_x;
    assign in_v = i_ctl.axis_y ? i_up_x : i_up_y;
    assign e_bu = i_up_end ? r_fu : in_u;
    assign e_bv = i_up_end ? r_fv : in_v;
    assign ia   = inside_b(r_pu, i_bound, i_ctl.keep_below);
    assign ib   = inside_b(e_bu, i_bound, i_ctl.keep_below);

    assign o_up_ready = (r_state == S_IDLE);
    assign acc        = i_up_valid && o_up_ready;
    assign out_free   = !r_ovld || i_dn_ready;
    assign emit_go    = (r_state == S_EMIT) && out_free && (r_do_cross || r_do_b || r_do_end);

    assign da = $signed({r_bv[CB-1], r_bv}) - $signed({r_av[CB-1], r_av});
    assign dn = $signed({i_bound[CB-1], i_bound}) - $signed({r_au[CB-1], r_au});
    assign dd = $signed({r_bu[CB-1], r_bu}) - $signed({r_au[CB-1], r_au});

    assign msum = {1'b0, r_ph} + (r_pl[0] ? {1'b0, r_ma} : {(W+1){1'b0}});
    assign dtry = {r_ph, r_pl[W-1]};
    assign dge  = dtry >= {1'b0, r_md};
    assign sq   = r_neg ? W'(~r_pl + 1'b1) : r_pl;
    assign fsum = {r_av[CB-1], r_av} + sq;

    assign o_dn_valid = r_ovld;
    assign o_dn_end   = r_oend;
    assign o_dn_x     = i_ctl.axis_y ? r_ov : r_ou;
    assign o_dn_y     = i_ctl.axis_y ? r_ou : r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_has_first <= 1'b0;
            r_fu <= '0; r_fv <= '0; r_pu <= '0; r_pv <= '0;
            r_do_cross  <= 1'b0;
            r_do_b      <= 1'b0;
            r_do_end    <= 1'b0;
            r_ovld      <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (r_ovld && i_dn_ready && !emit_go) begin
                r_ovld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        r_au <= r_pu;
                        r_av <= r_pv;
                        r_bu <= e_bu;
                        r_bv <= e_bv;
                        r_do_end <= i_up_end;
                        if (i_up_end && !r_has_first) begin
                            r_do_cross <= 1'b0;
                            r_do_b     <= 1'b0;
                            r_state    <= S_EMIT;
                        end else if (!i_up_end && !r_has_first) begin
                            r_has_first <= 1'b1;
                            r_fu <= in_u; r_fv <= in_v;
                            r_pu <= in_u; r_pv <= in_v;
                        end else begin
                            if (i_up_end) begin
                                r_has_first <= 1'b0;
                            end else begin
                                r_pu <= in_u;
                                r_pv <= in_v;
                            end
                            r_do_b     <= ib;
                            r_do_cross <= ia != ib;
                            r_state    <= (ia != ib) ? S_PREP : S_EMIT;
                        end
                    end
                end
                S_PREP: begin
                    r_ma    <= absw(da);
                    r_md    <= absw(dd);
                    r_pl    <= absw(dn);
                    r_ph    <= '0;
                    r_neg   <= da[W-1] ^ dn[W-1] ^ dd[W-1];
                    r_cnt   <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    // shift-add, least significant multiplier bit first
                    r_ph  <= msum[W:1];
                    r_pl  <= {msum[0], r_pl[W-1:1]};
                    if (r_cnt == CW'(W - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DIV: begin
                    // restoring division, quotient bits enter at the bottom
                    r_ph  <= dge ? W'(dtry - {1'b0, r_md}) : dtry[W-1:0];
                    r_pl  <= {r_pl[W-2:0], dge};
                    if (r_cnt == CW'(W - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_FIN;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_FIN: begin
                    r_cv    <= fsum[CB-1:0];
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        if (r_do_cross) begin
                            r_ovld <= 1'b1; r_oend <= 1'b0;
                            r_ou <= i_bound; r_ov <= r_cv;
                            r_do_cross <= 1'b0;
                            if (!r_do_b && !r_do_end) r_state <= S_IDLE;
                        end else if (r_do_b) begin
                            r_ovld <= 1'b1; r_oend <= 1'b0;
                            r_ou <= r_bu; r_ov <= r_bv;
                            r_do_b <= 1'b0;
                            if (!r_do_end) r_state <= S_IDLE;
                        end else if (r_do_end) begin
                            r_ovld <= 1'b1; r_oend <= 1'b1;
                            r_ou <= '0; r_ov <= '0;
                            r_do_end <= 1'b0;
                            r_state  <= S_IDLE;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/prc_hold.sv @@
// Output stage: holds one clipped vertex back so the last one can carry the
// final flag, and reports an empty polygon. Depends on prc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module prc_hold import prc_pkg::*; #(
    parameter int COORD_BITS = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_up_valid,
    output logic                              o_up_ready,
    input  wire logic signed [COORD_BITS-1:0] i_up_x,
    input  wire logic signed [COORD_BITS-1:0] i_up_y,
    input  wire logic                         i_up_end,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic signed [COORD_BITS-1:0]      o_x,
    output logic signed [COORD_BITS-1:0]      o_y,
    output logic                              o_final,
    output logic                              o_empty
);
    logic                         r_held_vld, r_vld, r_fin, r_emp;
    logic signed [COORD_BITS-1:0] r_hx, r_hy, r_x, r_y;
    logic                         acc, out_load;

    assign o_up_ready = !r_vld || i_ready;
    assign acc        = i_up_valid && o_up_ready;
    assign out_load   = acc && (i_up_end || r_held_vld);
    assign o_valid    = r_vld;
    assign o_x        = r_x;
    assign o_y        = r_y;
    assign o_final    = r_fin;
    assign o_empty    = r_emp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_vld <= 1'b0;
            r_vld      <= 1'b0;
        end else begin
            if (r_vld && i_ready && !out_load) begin
                r_vld <= 1'b0;
            end
            if (acc) begin
                if (i_up_end) begin
                    r_vld      <= 1'b1;
                    r_fin      <= 1'b1;
                    r_emp      <= !r_held_vld;
                    r_x        <= r_held_vld ? r_hx : '0;
                    r_y        <= r_held_vld ? r_hy : '0;
                    r_held_vld <= 1'b0;
                end else begin
                    if (r_held_vld) begin
                        r_vld <= 1'b1;
                        r_fin <= 1'b0;
                        r_emp <= 1'b0;
                        r_x   <= r_hx;
                        r_y   <= r_hy;
                    end
                    r_hx       <= i_up_x;
                    r_hy       <= i_up_y;
                    r_held_vld <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/polygon_rect_clipper.sv @@
// Top level of the polygon rectangle clipper: configuration registers, the
// chain of four clip cells and the output stage. Depends on prc_pkg, prc_if,
// prc_cell and prc_hold.
`timescale 1ns / 1ps
`default_nettype none
// Clips a polygon, streamed one vertex request at a time with final_vertex on
// its last vertex, against the rectangle set by its four bound registers. Four
// cells in a row clip against max-x, max-y, min-x and min-y; a point on a
// boundary counts as outside. The result is a cyclic rotation of the textbook
// order, with out_final on the last vertex; a polygon that vanishes gives one
// result with empty_result and zero coordinates. Crossing points use
// y1 + trunc((y2-y1)*(B-x1)/(x2-x1)). Each cell holds one token at a time:
// it takes a vertex while idle and takes no other until it has forwarded
// every output through its output register. An edge that crosses the
// boundary also passes through a preparation step, the serial shift-add
// multiplier, the restoring divider and a final sum inside the cell.
// Cells work on successive tokens concurrently. Write the edge registers
// only while idle.
module polygon_rect_clipper import prc_pkg::*; #(
    parameter int COORD_BITS = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    prc_cfg_if.sink   i_cfg,
    prc_vtx_if.sink   i_vtx,
    prc_res_if.source o_res
);
    logic signed [COORD_BITS-1:0] r_left, r_right, r_bottom, r_top;

    // token links between neighbouring cells; link 0 is the vertex input
    logic                         lk_valid [NUM_CELLS+1];
    logic                         lk_ready [NUM_CELLS+1];
    logic signed [COORD_BITS-1:0] lk_x     [NUM_CELLS+1];
    logic signed [COORD_BITS-1:0] lk_y     [NUM_CELLS+1];
    logic                         lk_end   [NUM_CELLS+1];
    logic signed [COORD_BITS-1:0] bound    [NUM_CELLS];

    // configuration is always taken at once
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_right  <= COORD_BITS'(1023);
            r_bottom <= '0;
            r_top    <= COORD_BITS'(1023);
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_LEFT:   r_left   <= i_cfg.data;
                CFG_RIGHT:  r_right  <= i_cfg.data;
                CFG_BOTTOM: r_bottom <= i_cfg.data;
                CFG_TOP:    r_top    <= i_cfg.data;
                default:    r_left   <= r_left;
            endcase
        end
    end

    assign bound[0] = r_right;
    assign bound[1] = r_top;
    assign bound[2] = r_left;
    assign bound[3] = r_bottom;

    // feed vertex requests into the first cell
    assign lk_valid[0] = i_vtx.valid;
    assign i_vtx.ready = lk_ready[0];
    assign lk_x[0]     = i_vtx.vertex_x;
    assign lk_y[0]     = i_vtx.vertex_y;
    assign lk_end[0]   = 1'b0;

    // the final flag becomes a separate end token after the vertex itself
    logic r_end_pend;
    logic c0_valid, c0_end;
    logic c0_ready;

    assign c0_valid = r_end_pend || lk_valid[0];
    assign c0_end   = r_end_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end_pend <= 1'b0;
        end else if (r_end_pend) begin
            if (c0_ready) r_end_pend <= 1'b0;
        end else if (lk_valid[0] && c0_ready && i_vtx.final_vertex) begin
            r_end_pend <= 1'b1;
        end
    end

    assign lk_ready[0] = c0_ready && !r_end_pend;

    genvar g;
    generate
        for (g = 0; g < NUM_CELLS; g++) begin : g_cell
            if (g == 0) begin : g_first
                prc_cell #(.COORD_BITS(COORD_BITS)) u_cell (
                    .i_clk      (i_clk),
                    .i_rst_n    (i_rst_n),
                    .i_ctl      (stage_ctl(g)),
                    .i_bound    (bound[g]),
                    .i_up_valid (c0_valid),
                    .o_up_ready (c0_ready),
                    .i_up_x     (lk_x[0]),
                    .i_up_y     (lk_y[0]),
                    .i_up_end   (c0_end),
                    .o_dn_valid (lk_valid[g+1]),
                    .i_dn_ready (lk_ready[g+1]),
                    .o_dn_x     (lk_x[g+1]),
                    .o_dn_y     (lk_y[g+1]),
                    .o_dn_end   (lk_end[g+1])
                );
            end else begin : g_rest
                prc_cell #(.COORD_BITS(COORD_BITS)) u_cell (
                    .i_clk      (i_clk),
                    .i_rst_n    (i_rst_n),
                    .i_ctl      (stage_ctl(g)),
                    .i_bound    (bound[g]),
                    .i_up_valid (lk_valid[g]),
                    .o_up_ready (lk_ready[g]),
                    .i_up_x     (lk_x[g]),
                    .i_up_y     (lk_y[g]),
                    .i_up_end   (lk_end[g]),
                    .o_dn_valid (lk_valid[g+1]),
                    .i_dn_ready (lk_ready[g+1]),
                    .o_dn_x     (lk_x[g+1]),
                    .o_dn_y     (lk_y[g+1]),
                    .o_dn_end   (lk_end[g+1])
                );
            end
        end
    endgenerate

    prc_hold #(.COORD_BITS(COORD_BITS)) u_hold (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_up_valid (lk_valid[NUM_CELLS]),
        .o_up_ready (lk_ready[NUM_CELLS]),
        .i_up_x     (lk_x[NUM_CELLS]),
        .i_up_y     (lk_y[NUM_CELLS]),
        .i_up_end   (lk_end[NUM_CELLS]),
        .o_valid    (o_res.valid),
        .i_ready    (o_res.ready),
        .o_x        (o_res.out_x),
        .o_y        (o_res.out_y),
        .o_final    (o_res.out_final),
        .o_empty    (o_res.empty_result)
    );
endmodule
`default_nettype wire

@@ test/prc_tb_if.sv @@
// Testbench-side note: the channel interfaces come from the RTL file prc_if.sv.
// This file holds shared types for the checker. No dependencies.
`timescale 1ns / 1ps
package prc_tb_pkg;
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               fin;
        logic               emp;
    } t_clip_out;
endpackage

@@ test/prc_checker.sv @@
// Checker for the polygon rectangle clipper: watches the configuration,
// vertex and result channels, predicts clipped vertices and compares them.
// Depends on prc_pkg, prc_tb_pkg and the channel interfaces in prc_if.
`timescale 1ns / 1ps
module prc_checker import prc_pkg::*; import prc_tb_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    prc_cfg_if        cfg,
    prc_vtx_if        vtx,
    prc_res_if        res,
    output int        o_fail_cnt,
    output int        o_pending,
    output int        o_results
);
    localparam int MAX_OUT = 16;

    longint edge_reg [4];
    longint first_x [4], first_y [4], prev_x [4], prev_y [4];
    bit     has_first [4];
    bit     held_valid;
    longint held_x, held_y;
    t_clip_out step_buf [$];
    t_clip_out expected_verts [$];

    function automatic longint sx32(logic [31:0] v);
        return longint'(signed'(v));
    endfunction

    // trunc(a*n/d); magnitudes fit in 33 bits so the product fits in 66
    function automatic longint scaled_quot(longint a, longint n, longint d);
        logic signed [127:0] p;
        logic signed [127:0] q;
        if (d == 0) return 0;
        p = 128'(signed'(a)) * 128'(signed'(n));
        q = p / 128'(signed'(d));
        return longint'(q);
    endfunction

    function automatic bit in_bounds(int s, longint x, longint y);
        case (s)
            0: return x < edge_reg[CFG_RIGHT];
            1: return y < edge_reg[CFG_TOP];
            2: return x > edge_reg[CFG_LEFT];
            default: return y > edge_reg[CFG_BOTTOM];
        endcase
    endfunction

    task automatic push_out(longint x, longint y, bit fin, bit emp);
        t_clip_out o;
        o.x = x[31:0]; o.y = y[31:0]; o.fin = fin; o.emp = emp;
        step_buf = {step_buf, o};
    endtask

    task automatic clip_edge(int s, longint ax, longint ay, longint bx, longint by);
        bit ia, ib;
        longint ix, iy, b;
        ia = in_bounds(s, ax, ay);
        ib = in_bounds(s, bx, by);
        if (ia != ib) begin
            if (s == 0 || s == 2) begin
                b = (s == 0) ? edge_reg[CFG_RIGHT] : edge_reg[CFG_LEFT];
                if (bx == ax) begin ix = ax; iy = ay; end
                else begin
                    ix = b;
                    iy = ay + scaled_quot(by - ay, b - ax, bx - ax);
                end
            end else begin
                b = (s == 1) ? edge_reg[CFG_TOP] : edge_reg[CFG_BOTTOM];
                if (by == ay) begin ix = ax; iy = ay; end
                else begin
                    iy = b;
                    ix = ax + scaled_quot(bx - ax, b - ay, by - ay);
                end
            end
            feed_stage(s + 1, 0, ix, iy);
        end
        if (ib) feed_stage(s + 1, 0, bx, by);
    endtask

    task automatic feed_stage(int s, bit is_end, longint x, longint y);
        longint px, py;
        if (s >= 4) begin
            if (is_end) begin
                if (held_valid) push_out(held_x, held_y, 1, 0);
                else push_out(0, 0, 1, 1);
                held_valid = 0;
            end else begin
                if (held_valid) push_out(held_x, held_y, 0, 0);
                held_x = x; held_y = y; held_valid = 1;
            end
            return;
        end
        if (is_end) begin
            if (has_first[s]) begin
                has_first[s] = 0;
                clip_edge(s, prev_x[s], prev_y[s], first_x[s], first_y[s]);
            end
            feed_stage(s + 1, 1, 0, 0);
            return;
        end
        if (!has_first[s]) begin
            has_first[s] = 1;
            first_x[s] = x; first_y[s] = y; prev_x[s] = x; prev_y[s] = y;
            return;
        end
        px = prev_x[s]; py = prev_y[s];
        prev_x[s] = x; prev_y[s] = y;
        clip_edge(s, px, py, x, y);
    endtask

    task automatic report_mismatch(string what, t_clip_out got, t_clip_out exp);
        $display("[%0t] result mismatch (%s): got x=%0d y=%0d f=%0b e=%0b, %s",
            $realtime, what, got.x, got.y, got.fin, got.emp,
            $sformatf("exp x=%0d y=%0d f=%0b e=%0b", exp.x, exp.y, exp.fin, exp.emp));
        o_fail_cnt++;
    endtask

    assign o_pending = expected_verts.size();

    always @(posedge i_clk) begin
        t_clip_out got, exp;
        int n;
        if (!i_rst_n) begin
            edge_reg[CFG_LEFT] = 0; edge_reg[CFG_RIGHT] = 1023;
            edge_reg[CFG_BOTTOM] = 0; edge_reg[CFG_TOP] = 1023;
            for (int i = 0; i < 4; i++) begin
                has_first[i] = 0; first_x[i] = 0; first_y[i] = 0;
                prev_x[i] = 0; prev_y[i] = 0;
            end
            held_valid = 0; held_x = 0; held_y = 0;
            expected_verts.delete();
        end else begin
            if (res.valid && res.ready) begin
                got.x = res.out_x; got.y = res.out_y;
                got.fin = res.out_final; got.emp = res.empty_result;
                o_results++;
                if (expected_verts.size() == 0) begin
                    exp = '0;
                    report_mismatch("unexpected", got, exp);
                end else begin
                    exp = expected_verts.pop_front();
                    if (got.x !== exp.x) report_mismatch("out_x", got, exp);
                    if (got.y !== exp.y) report_mismatch("out_y", got, exp);
                    if (got.fin !== exp.fin) report_mismatch("out_final", got, exp);
                    if (got.emp !== exp.emp) report_mismatch("empty_result", got, exp);
                end
            end
            if (cfg.valid && cfg.ready)
                edge_reg[cfg.index] = sx32(cfg.data);
            if (vtx.valid && vtx.ready) begin
                step_buf.delete();
                feed_stage(0, 0, sx32(vtx.vertex_x), sx32(vtx.vertex_y));
                if (vtx.final_vertex) feed_stage(0, 1, 0, 0);
                n = step_buf.size();
                for (int i = 0; i < n && i < MAX_OUT; i++)
                    expected_verts = {expected_verts, (n > MAX_OUT && i == MAX_OUT - 1)
                                                      ? step_buf[n - 1] : step_buf[i]};
            end
        end
    end
endmodule

@@ test/tb.sv @@
// Top of the polygon rectangle clipper testbench: clock, reset, vertex and
// configuration stimulus, result back-pressure and the verdict.
// Depends on prc_pkg, prc_if, prc_checker and the clipper RTL.
`timescale 1ns / 1ps
module tb;
    import prc_pkg::*;

    localparam int    N_RANDOM = 400;
    localparam int    DRAIN    = 600;   // cycles: several crossing edges' worth

    logic i_clk;
    logic i_rst_n;
    int   fail_cnt, pending, results;
    int   polygons;
    bit   calm;            // hold both sides busy-free for a stretch
    bit   timed_out;

    prc_cfg_if #(32) cfg_ch ();
    prc_vtx_if #(32) vtx_ch ();
    prc_res_if #(32) res_ch ();

    polygon_rect_clipper #(.COORD_BITS(32)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (cfg_ch.sink),
        .i_vtx  (vtx_ch.sink),
        .o_res  (res_ch.source)
    );

    prc_checker chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .cfg       (cfg_ch),
        .vtx       (vtx_ch),
        .res       (res_ch),
        .o_fail_cnt(fail_cnt),
        .o_pending (pending),
        .o_results (results)
    );

    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    // Result back-pressure: drop ready about a quarter of the time, except
    // during the calm stretch.
    always @(negedge i_clk) begin
        res_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 24);
    end

    // Write one edge register; hold the request until it is taken.
    task automatic write_edge(logic [1:0] idx, logic signed [31:0] val);
        cfg_ch.index = idx;
        cfg_ch.data  = val;
        cfg_ch.valid = 1'b1;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Wait until every expected result has come, then let the cells settle.
    task automatic wait_idle();
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);
    endtask

    task automatic set_rect(int l, int r, int b, int t);
        wait_idle();
        write_edge(CFG_LEFT, l);
        write_edge(CFG_RIGHT, r);
        write_edge(CFG_BOTTOM, b);
        write_edge(CFG_TOP, t);
    endtask

    // Send one vertex request, with a random gap before it outside the calm stretch.
    task automatic send_vertex(logic signed [31:0] x, logic signed [31:0] y, bit fin);
        if (!calm)
            while ($urandom_range(99) < 24) @(negedge i_clk);
        vtx_ch.vertex_x     = x;
        vtx_ch.vertex_y     = y;
        vtx_ch.final_vertex = fin;
        vtx_ch.valid        = 1'b1;
        @(posedge i_clk);
        while (!vtx_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        vtx_ch.valid = 1'b0;
        if (fin) polygons++;
    endtask

    // Random coordinate: mostly from lo-200 to hi+200, sometimes anywhere.
    function automatic logic signed [31:0] rand_coord(int lo, int hi);
        if ($urandom_range(9) == 0) return $urandom;
        return lo + $signed($urandom_range(hi - lo + 400)) - 200;
    endfunction

    task automatic send_polygon(int nv, int lo, int hi);
        for (int i = 0; i < nv; i++)
            send_vertex(rand_coord(lo, hi), rand_coord(lo, hi), i == nv - 1);
    endtask

    initial begin
        timed_out = 0;
        #20ms;
        timed_out = 1;
        $display("Timeout with %0d results outstanding", pending);
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int sent;
        int rect_step;
        i_rst_n = 1'b0;
        calm = 1'b0;
        polygons = 0;
        cfg_ch.valid = 1'b0; cfg_ch.index = CFG_LEFT; cfg_ch.data = '0;
        vtx_ch.valid = 1'b0; vtx_ch.vertex_x = '0; vtx_ch.vertex_y = '0;
        vtx_ch.final_vertex = 1'b0;
        res_ch.ready = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: default rectangle, all-inside, on-boundary, single vertex.
        send_polygon(0, 0, 0);
        send_vertex(10, 10, 0); send_vertex(500, 10, 0); send_vertex(10, 500, 1);
        send_vertex(0, 0, 0); send_vertex(1023, 0, 0); send_vertex(1023, 1023, 1);
        send_vertex(100, 100, 1);
        send_vertex(0, 0, 1);
        // Polygon straddling all four sides of the box.
        send_vertex(-500, 512, 0); send_vertex(512, -500, 0);
        send_vertex(1600, 512, 0); send_vertex(512, 1600, 1);
        // Extremes of the coordinate range.
        send_vertex(32'sh8000_0000, 32'sh8000_0000, 0);
        send_vertex(32'sh7fff_ffff, 32'sh8000_0000, 0);
        send_vertex(32'sh7fff_ffff, 32'sh7fff_ffff, 0);
        send_vertex(32'sh8000_0000, 32'sh7fff_ffff, 1);
        // Extreme rectangle: the whole plane bar its edges.
        set_rect(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
        send_vertex(32'sh8000_0000, 0, 0); send_vertex(5, 32'sh7fff_ffff, 0);
        send_vertex(32'sh7fff_ffff, -7, 0); send_vertex(3, 32'sh8000_0001, 1);
        // Inverted rectangle: everything vanishes.
        set_rect(100, -100, 100, -100);
        send_vertex(0, 0, 0); send_vertex(50, 0, 0); send_vertex(0, 50, 1);

        // Random: several rectangles, mostly small polygons near the box.
        set_rect(-300, 300, -200, 250);
        sent = 0;
        rect_step = 0;
        while (sent < N_RANDOM) begin
            int nv;
            if (rect_step == 0 && sent >= 120) begin
                set_rect(0, 1023, 0, 1023);
                rect_step = 1;
            end
            if (rect_step == 1 && sent >= 240) begin
                set_rect(32'sh8000_0000, 32'sh7fff_ffff, -50, 50);
                rect_step = 2;
            end
            if (rect_step == 2 && sent >= 320) begin
                // Hold off until every expected result has come.
                while (pending != 0) @(negedge i_clk);
                rect_step = 3;
            end
            calm = (sent >= 160 && sent < 220);
            nv = $urandom_range(8, 1);
            if ($urandom_range(19) == 0) nv = $urandom_range(20, 12);
            send_polygon(nv, -400, 400);
            sent += nv;
        end
        calm = 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);
        $display("Sent %0d polygons, checked %0d clipped vertices over several rectangles",
                 polygons, results);
        if (fail_cnt == 0 && !timed_out) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

@@ polygon_rect_clipper.f @@
rtl/core/prc_pkg.sv
rtl/core/prc_if.sv
rtl/core/prc_cell.sv
rtl/core/prc_hold.sv
rtl/core/polygon_rect_clipper.sv
test/prc_tb_if.sv
test/prc_checker.sv
test/tb.sv
